// ----- rtl/core/mi44_pkg.sv -----
// Shared types, constants and helper functions for the 4x4 matrix inverse.
// Used by the datapath, divider, controller and top level; depends on nothing.
package mi44_pkg;

    // Fixed arithmetic widths, wide enough for every element width in range.
    localparam int LIMB_W = 32;
    localparam int P_W    = 64;
    localparam int COF_W  = 128;
    localparam int ACC_W  = 160;
    localparam int DIV_W  = 192;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int MAT_DEPTH = 16;
    localparam int ADDR_W = 4;

    // Multiplier operand selection.
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_AM   = 3'd1;
    localparam logic [2:0] MUL_AP0  = 3'd2;
    localparam logic [2:0] MUL_AP1  = 3'd3;
    localparam logic [2:0] MUL_AC   = 3'd4;

    // Accumulator operations.
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_CLR  = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              mat_wr;
        logic [ADDR_W-1:0] mat_waddr;
        logic              mat_rd;
        logic [ADDR_W-1:0] mat_raddr;
        logic              a_ld;
        logic [2:0]        mul_op;
        logic [1:0]        limb;
        logic              p_ld;
        logic [1:0]        acc_op;
        logic [1:0]        acc_sh;
        logic              cof_wr;
        logic [ADDR_W-1:0] cof_waddr;
        logic              cof_rd;
        logic [ADDR_W-1:0] cof_raddr;
        logic              det_ld;
        logic              div_start;
        logic              out_ld_sing;
        logic              out_ld_div;
        logic [ADDR_W-1:0] out_idx;
    } mi44_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic det_zero;
        logic div_done;
        logic out_valid;
    } mi44_status_t;

    // Index n of the three kept rows or columns once index excl is removed.
    function automatic logic [1:0] skip_idx(input logic [1:0] excl, input logic [1:0] n);
        return (n < excl) ? n : n + 2'd1;
    endfunction

    // Minor column used by row n in each of the six triple-product terms.
    // Terms zero to two are the positive diagonals, three to five the negative ones.
    function automatic logic [1:0] col_perm(input logic [2:0] term, input logic [1:0] n);
        logic [1:0] r;
        r = n;
        case (term)
            3'd1:    r = (n == 2'd0) ? 2'd1 : (n == 2'd1) ? 2'd2 : 2'd0;
            3'd2:    r = (n == 2'd0) ? 2'd2 : (n == 2'd1) ? 2'd0 : 2'd1;
            3'd3:    r = (n == 2'd0) ? 2'd2 : (n == 2'd1) ? 2'd1 : 2'd0;
            3'd4:    r = (n == 2'd0) ? 2'd0 : (n == 2'd1) ? 2'd2 : 2'd1;
            3'd5:    r = (n == 2'd0) ? 2'd1 : (n == 2'd1) ? 2'd0 : 2'd2;
            default: r = n;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/matrix_inverse_4x4_top.sv -----
// 4x4 fixed-point matrix inverse by the adjugate. Sixteen elements load one per cycle
// while s_tvalid is high; the cofactors and then the determinant are built on the shared
// multiplier, and each result goes through the bit-serial divider unless the matrix is singular.
// Synchronous active-low reset clears the controller, load count, divider state,
// determinant-zero flag and result valid.
module matrix_inverse_4x4_top import mi44_pkg::*; #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [33:32] row, [35:34] col, rest zero
    output logic [1:0]  m_tuser,   // [0] singular, [1] saturated
    output logic        m_tlast
);

    mi44_cmd_t    cmd;
    mi44_status_t status;

    mi44_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mi44_dpath #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/mi44_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the element store and the cofactor store.
module mi44_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mi44_div.sv -----
// Restoring divider: cofactor scaled by 2^(2*FRAC_BITS) over the determinant magnitude.
// Gives a quotient rounded toward zero and saturated; depends on mi44_pkg.
module mi44_div import mi44_pkg::*; #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COF_W-1:0]      num_i,
    input  logic [ACC_W-1:0]      dmag_i,
    input  logic                  den_neg_i,
    output logic                  done_o,
    output logic [ELEM_WIDTH-1:0] value_o,
    output logic                  sat_o
);

    localparam int CNT_W = $clog2(ELEM_WIDTH + 2);
    localparam logic [1:0] DV_IDLE = 2'd0;
    localparam logic [1:0] DV_OVF  = 2'd1;
    localparam logic [1:0] DV_ITER = 2'd2;
    localparam logic [1:0] DV_FIN  = 2'd3;

    logic [1:0]            state_reg;
    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dsh_reg;
    logic [ELEM_WIDTH:0]   q_reg;
    logic                  neg_reg;
    logic                  ovf_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [ELEM_WIDTH-1:0] value_reg;
    logic                  sat_reg;

    logic [DIV_W-1:0]      num_ext;
    logic [DIV_W-1:0]      num_sh;
    logic [DIV_W-1:0]      den_sh;
    logic                  ge;
    logic [ELEM_WIDTH:0]   lim;
    logic                  clamp;
    logic [ELEM_WIDTH:0]   q_sel;
    logic [ELEM_WIDTH:0]   val_full;

    // Scaled numerator, initial shifted divisor and the final clamp.
    always_comb begin
        num_ext  = {{(DIV_W-COF_W){num_i[COF_W-1]}}, num_i};
        num_sh   = num_ext << (2 * FRAC_BITS);
        den_sh   = {{(DIV_W-ACC_W){1'b0}}, dmag_i} << (ELEM_WIDTH + 1);
        ge       = (rem_reg >= dsh_reg);
        lim      = ({{ELEM_WIDTH{1'b0}}, 1'b1} << (ELEM_WIDTH - 1))
                   - {{ELEM_WIDTH{1'b0}}, ~neg_reg};
        clamp    = ovf_reg || (q_reg > lim);
        q_sel    = clamp ? lim : q_reg;
        val_full = neg_reg ? (~q_sel + 1'b1) : q_sel;
    end

    // Division sequencer: overflow test, then one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        neg_reg   <= num_i[COF_W-1] ^ den_neg_i;
                        rem_reg   <= num_i[COF_W-1] ? (~num_sh + 1'b1) : num_sh;
                        dsh_reg   <= den_sh;
                        ovf_reg   <= 1'b0;
                        q_reg     <= '0;
                        state_reg <= DV_OVF;
                    end
                end
                DV_OVF: begin
                    if (ge) begin
                        ovf_reg   <= 1'b1;
                        state_reg <= DV_FIN;
                    end else begin
                        dsh_reg   <= dsh_reg >> 1;
                        cnt_reg   <= CNT_W'(ELEM_WIDTH + 1);
                        state_reg <= DV_ITER;
                    end
                end
                DV_ITER: begin
                    if (ge) begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[ELEM_WIDTH-1:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN: begin
                    value_reg <= val_full[ELEM_WIDTH-1:0];
                    sat_reg   <= clamp;
                    done_reg  <= 1'b1;
                    state_reg <= DV_IDLE;
                end
                default: state_reg <= DV_IDLE;
            endcase
        end
    end

    assign done_o  = done_reg;
    assign value_o = value_reg;
    assign sat_o   = sat_reg;

endmodule

// ----- rtl/core/mi44_dpath.sv -----
// Datapath: element and cofactor stores, shared multiplier, accumulator,
// determinant, divider and result register. Depends on mi44_pkg, mi44_ram, mi44_div.
module mi44_dpath import mi44_pkg::*; #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  mi44_cmd_t    cmd,
    output mi44_status_t status,
    input  logic [31:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic [ELEM_WIDTH-1:0] mat_q;
    logic [COF_W-1:0]      cof_q;
    logic [ELEM_WIDTH-1:0] a_reg;
    logic [P_W-1:0]        p_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [ACC_W-1:0]      dmag_reg;
    logic                  det_neg_reg;
    logic                  det_zero_reg;

    logic signed [MUL_W-1:0] opa;
    logic signed [MUL_W-1:0] opb;
    logic [LIMB_W-1:0]       cof_limb;
    logic [ACC_W-1:0]        addend;

    logic                  div_done;
    logic [ELEM_WIDTH-1:0] div_value;
    logic                  div_sat;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [1:0]  out_row_reg;
    logic [1:0]  out_col_reg;
    logic        out_sing_reg;
    logic        out_sat_reg;
    logic        out_last_reg;

    // Element store, written from the input beats.
    mi44_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAT_DEPTH)) u_mat_ram (
        .aclk    (aclk),
        .wr_en   (cmd.mat_wr),
        .wr_addr (cmd.mat_waddr),
        .wr_data (s_tdata[ELEM_WIDTH-1:0]),
        .rd_en   (cmd.mat_rd),
        .rd_addr (cmd.mat_raddr),
        .rd_data (mat_q)
    );

    // Cofactor store, written from the accumulator.
    mi44_ram #(.WIDTH(COF_W), .DEPTH(MAT_DEPTH)) u_cof_ram (
        .aclk    (aclk),
        .wr_en   (cmd.cof_wr),
        .wr_addr (cmd.cof_waddr),
        .wr_data (acc_reg[COF_W-1:0]),
        .rd_en   (cmd.cof_rd),
        .rd_addr (cmd.cof_raddr),
        .rd_data (cof_q)
    );

    // Multiplier operands: low limbs are unsigned, the top limb carries the sign.
    always_comb begin
        cof_limb = cof_q[cmd.limb*LIMB_W +: LIMB_W];
        opa      = {{(MUL_W-ELEM_WIDTH){a_reg[ELEM_WIDTH-1]}}, a_reg};
        case (cmd.mul_op)
            MUL_AM:  opb = {{(MUL_W-ELEM_WIDTH){mat_q[ELEM_WIDTH-1]}}, mat_q};
            MUL_AP0: opb = {1'b0, p_reg[LIMB_W-1:0]};
            MUL_AP1: opb = {p_reg[P_W-1], p_reg[P_W-1:LIMB_W]};
            MUL_AC:  opb = (cmd.limb == 2'd3) ? {cof_limb[LIMB_W-1], cof_limb}
                                              : {1'b0, cof_limb};
            default: opb = '0;
        endcase
        addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg} << {cmd.acc_sh, 5'b0};
    end

    // Operand registers, product register and accumulator.
    always_ff @(posedge aclk) begin
        if (cmd.a_ld) begin
            a_reg <= mat_q;
        end
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= opa * opb;
        end
        if (cmd.p_ld) begin
            p_reg <= prod_reg[P_W-1:0];
        end
        case (cmd.acc_op)
            ACC_CLR: acc_reg <= '0;
            ACC_ADD: acc_reg <= acc_reg + addend;
            ACC_SUB: acc_reg <= acc_reg - addend;
            default: acc_reg <= acc_reg;
        endcase
    end

    // Determinant sign, magnitude and zero test.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_zero_reg <= 1'b0;
        end else if (cmd.det_ld) begin
            det_zero_reg <= (acc_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.det_ld) begin
            det_neg_reg <= acc_reg[ACC_W-1];
            dmag_reg    <= acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        end
    end

    mi44_div #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .num_i     (cof_q),
        .dmag_i    (dmag_reg),
        .den_neg_i (det_neg_reg),
        .done_o    (div_done),
        .value_o   (div_value),
        .sat_o     (div_sat)
    );

    // Result register; the controller loads it only while it is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_ld_sing || cmd.out_ld_div) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld_sing || cmd.out_ld_div) begin
            out_row_reg  <= cmd.out_idx[3:2];
            out_col_reg  <= cmd.out_idx[1:0];
            out_last_reg <= (cmd.out_idx == 4'd15);
            out_sing_reg <= cmd.out_ld_sing;
            out_sat_reg  <= cmd.out_ld_div & div_sat;
            out_value_reg <= cmd.out_ld_div
                ? {{(32-ELEM_WIDTH+1){div_value[ELEM_WIDTH-1]}}, div_value[ELEM_WIDTH-2:0]}
                : 32'd0;
        end
    end

    assign status.det_zero  = det_zero_reg;
    assign status.div_done  = div_done;
    assign status.out_valid = out_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_col_reg, out_row_reg, out_value_reg};
    assign m_tuser  = {out_sat_reg, out_sing_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/core/mi44_ctrl.sv -----
// Controller: load counting, cofactor and determinant sequencing, result issue.
// Drives the datapath through mi44_cmd_t; depends on mi44_pkg.
module mi44_ctrl import mi44_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  mi44_status_t status,
    output mi44_cmd_t    cmd
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_COF    = 3'd1;
    localparam logic [2:0] ST_CWR    = 3'd2;
    localparam logic [2:0] ST_DET    = 3'd3;
    localparam logic [2:0] ST_DETLD  = 3'd4;
    localparam logic [2:0] ST_ORD    = 3'd5;
    localparam logic [2:0] ST_OSTART = 3'd6;
    localparam logic [2:0] ST_OWAIT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] ldcnt_reg, ldcnt_next;
    logic [3:0] idx_reg, idx_next;
    logic [2:0] term_reg, term_next;
    logic [2:0] sub_reg, sub_next;

    logic [1:0] ci, cj, row_n, col_n;
    logic       subtract;
    logic [1:0] acc_dir;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ldcnt_reg <= '0;
            idx_reg   <= '0;
            term_reg  <= '0;
            sub_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ldcnt_reg <= ldcnt_next;
            idx_reg   <= idx_next;
            term_reg  <= term_next;
            sub_reg   <= sub_next;
        end
    end

    // Element address of the current term and row, and the term sign.
    always_comb begin
        ci       = idx_reg[3:2];
        cj       = idx_reg[1:0];
        row_n    = skip_idx(ci, sub_reg[1:0]);
        col_n    = skip_idx(cj, col_perm(term_reg, sub_reg[1:0]));
        subtract = (term_reg >= 3'd3) ^ (ci[0] ^ cj[0]);
        acc_dir  = subtract ? ACC_SUB : ACC_ADD;
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        ldcnt_next = ldcnt_reg;
        idx_next   = idx_reg;
        term_next  = term_reg;
        sub_next   = sub_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready      = 1'b1;
                cmd.mat_wr    = s_tvalid;
                cmd.mat_waddr = ldcnt_reg;
                if (s_tvalid) begin
                    ldcnt_next = ldcnt_reg + 1'b1;
                    if (ldcnt_reg == 4'd15) begin
                        state_next = ST_COF;
                        idx_next   = '0;
                        term_next  = '0;
                        sub_next   = '0;
                    end
                end
            end
            // Triple products, one after another, into the accumulator.
            ST_COF: begin
                cmd.mat_raddr = {row_n, col_n};
                sub_next      = sub_reg + 1'b1;
                unique case (sub_reg)
                    3'd0: begin
                        cmd.mat_rd = 1'b1;
                        cmd.acc_op = (term_reg == 3'd0) ? ACC_CLR : ACC_NONE;
                    end
                    3'd1: begin
                        cmd.a_ld   = 1'b1;
                        cmd.mat_rd = 1'b1;
                    end
                    3'd2: begin
                        cmd.mul_op = MUL_AM;
                        cmd.mat_rd = 1'b1;
                    end
                    3'd3: begin
                        cmd.p_ld = 1'b1;
                        cmd.a_ld = 1'b1;
                    end
                    3'd4: cmd.mul_op = MUL_AP0;
                    3'd5: begin
                        cmd.mul_op = MUL_AP1;
                        cmd.acc_op = acc_dir;
                        cmd.acc_sh = 2'd0;
                    end
                    3'd6: begin
                        cmd.acc_op = acc_dir;
                        cmd.acc_sh = 2'd1;
                        sub_next   = '0;
                        term_next  = term_reg + 1'b1;
                        if (term_reg == 3'd5) begin
                            state_next = ST_CWR;
                        end
                    end
                    default: sub_next = '0;
                endcase
            end
            ST_CWR: begin
                cmd.cof_wr    = 1'b1;
                cmd.cof_waddr = idx_reg;
                idx_next      = idx_reg + 1'b1;
                term_next     = '0;
                sub_next      = '0;
                state_next    = (idx_reg == 4'd15) ? ST_DET : ST_COF;
            end
            // First-row expansion: element times cofactor, one limb a cycle.
            ST_DET: begin
                cmd.mat_raddr = {2'b00, cj};
                cmd.cof_raddr = {2'b00, cj};
                sub_next      = sub_reg + 1'b1;
                unique case (sub_reg)
                    3'd0: begin
                        cmd.mat_rd = 1'b1;
                        cmd.cof_rd = 1'b1;
                        cmd.acc_op = (cj == 2'd0) ? ACC_CLR : ACC_NONE;
                    end
                    3'd1: cmd.a_ld = 1'b1;
                    3'd2: begin
                        cmd.mul_op = MUL_AC;
                        cmd.limb   = 2'd0;
                    end
                    3'd3: begin
                        cmd.mul_op = MUL_AC;
                        cmd.limb   = 2'd1;
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = 2'd0;
                    end
                    3'd4: begin
                        cmd.mul_op = MUL_AC;
                        cmd.limb   = 2'd2;
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = 2'd1;
                    end
                    3'd5: begin
                        cmd.mul_op = MUL_AC;
                        cmd.limb   = 2'd3;
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = 2'd2;
                    end
                    3'd6: begin
                        cmd.acc_op = ACC_ADD;
                        cmd.acc_sh = 2'd3;
                        sub_next   = '0;
                        idx_next   = idx_reg + 1'b1;
                        if (cj == 2'd3) begin
                            state_next = ST_DETLD;
                        end
                    end
                    default: sub_next = '0;
                endcase
            end
            ST_DETLD: begin
                cmd.det_ld = 1'b1;
                idx_next   = '0;
                state_next = ST_ORD;
            end
            // Results: read the transposed cofactor once the result register is free.
            ST_ORD: begin
                if (!status.out_valid) begin
                    cmd.cof_rd    = 1'b1;
                    cmd.cof_raddr = {idx_reg[1:0], idx_reg[3:2]};
                    state_next    = ST_OSTART;
                end
            end
            ST_OSTART: begin
                cmd.out_idx = idx_reg;
                if (status.det_zero) begin
                    cmd.out_ld_sing = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = (idx_reg == 4'd15) ? ST_LOAD : ST_ORD;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_OWAIT;
                end
            end
            ST_OWAIT: begin
                cmd.out_idx = idx_reg;
                if (status.div_done) begin
                    cmd.out_ld_div = 1'b1;
                    idx_next       = idx_reg + 1'b1;
                    state_next     = (idx_reg == 4'd15) ? ST_LOAD : ST_ORD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

endmodule
